// ===== design/cnia_pkg.sv =====
// Shared types and constants for the CAN node-ID allocation client.
package cnia_pkg;

  localparam int UidBytes  = 16;
  localparam int MaxReqUid = 6;
  localparam int DivBits   = 31;
  localparam int DivCntW   = $clog2(DivBits + 1);

  localparam logic [2:0] CfgPreferredId = 3'd0;
  localparam logic [2:0] CfgStaticId    = 3'd1;
  localparam logic [2:0] CfgUidUpper    = 3'd2;
  localparam logic [2:0] CfgUidLower    = 3'd3;
  localparam logic [2:0] CfgMinPeriod   = 3'd4;
  localparam logic [2:0] CfgMaxDelay    = 3'd5;

  localparam logic       OpPoll  = 1'b0;
  localparam logic       OpAlloc = 1'b1;

  localparam logic [15:0] MinPeriodReset = 16'd600;
  localparam logic [15:0] MaxDelayReset  = 16'd400;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now_ms;
    logic [30:0] random_draw;
    logic        from_anonymous;
    logic [4:0]  uid_len;
    logic [63:0] msg_uid_upper;
    logic [63:0] msg_uid_lower;
    logic [6:0]  assigned_node_id;
  } in_word_t;

  typedef struct packed {
    logic        request_valid;
    logic [7:0]  request_first_byte;
    logic [47:0] request_uid_bytes;
    logic [2:0]  request_uid_count;
    logic [6:0]  local_node_id;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } ctrl_stat_t;

endpackage

// ===== design/cnia_div.sv =====
// Bit-serial remainder unit: dividend modulo divisor, one bit per cycle.
module cnia_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cnia_pkg::DivBits-1:0] dividend,
  input  logic [15:0]                divisor,
  output logic                       busy,
  output logic [15:0]                remainder
);

  logic [cnia_pkg::DivBits-1:0] dvd_r, dvd_nxt;
  logic [15:0]                  rem_r, rem_nxt;
  logic [cnia_pkg::DivCntW-1:0] cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic [16:0]                  trial;
  logic                         ge;

  always_comb begin
    trial    = {rem_r, dvd_r[cnia_pkg::DivBits-1]};
    ge       = trial >= {1'b0, divisor};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = cnia_pkg::DivCntW'(cnia_pkg::DivBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[cnia_pkg::DivBits-2:0], 1'b0};
      rem_nxt  = ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != cnia_pkg::DivCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = busy_r;
  assign remainder = rem_r;

endmodule

// ===== design/cnia_dp.sv =====
// Datapath: configuration, allocation state, deadline arithmetic and result word.
module cnia_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cnia_pkg::in_word_t   in_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 out_stall,
  input  cnia_pkg::ctrl_cmd_t  cmd,
  output cnia_pkg::ctrl_stat_t stat,
  output logic                 out_valid,
  output cnia_pkg::out_word_t  out_data
);

  logic [6:0]  pref_id_r, static_id_r;
  logic [63:0] uid_upper_r, uid_lower_r;
  logic [15:0] min_period_r, max_delay_r;

  logic [6:0]  alloc_r, alloc_nxt;
  logic [4:0]  off_r, off_nxt;
  logic [31:0] next_req_r, next_req_nxt;

  cnia_pkg::in_word_t  item_r;
  cnia_pkg::out_word_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic        div_busy;
  logic [15:0] div_rem;
  logic [15:0] extra;
  logic [31:0] dl_full, dl_part;
  logic [6:0]  local_id;
  logic [4:0]  off_c, len_c, left_bytes;
  logic [127:0] uid_all, msg_all, shifted;
  logic        mismatch;

  cnia_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.load),
    .dividend  (in_data.random_draw),
    .divisor   (max_delay_r),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pref_id_r    <= '0;
      static_id_r  <= '0;
      uid_upper_r  <= '0;
      uid_lower_r  <= '0;
      min_period_r <= cnia_pkg::MinPeriodReset;
      max_delay_r  <= cnia_pkg::MaxDelayReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cnia_pkg::CfgPreferredId: pref_id_r    <= cfg_data[6:0];
        cnia_pkg::CfgStaticId:    static_id_r  <= cfg_data[6:0];
        cnia_pkg::CfgUidUpper:    uid_upper_r  <= cfg_data;
        cnia_pkg::CfgUidLower:    uid_lower_r  <= cfg_data;
        cnia_pkg::CfgMinPeriod:   min_period_r <= cfg_data[15:0];
        cnia_pkg::CfgMaxDelay:    max_delay_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    extra    = (max_delay_r == '0) ? '0 : div_rem;
    dl_part  = item_r.now_ms + {16'b0, extra};
    dl_full  = dl_part + {16'b0, min_period_r};
    local_id = (static_id_r != '0) ? static_id_r : alloc_r;
    uid_all  = {uid_upper_r, uid_lower_r};
    msg_all  = {item_r.msg_uid_upper, item_r.msg_uid_lower};
    off_c    = (off_r > 5'(cnia_pkg::UidBytes)) ? 5'(cnia_pkg::UidBytes) : off_r;
    len_c    = (item_r.uid_len > 5'(cnia_pkg::UidBytes)) ? 5'(cnia_pkg::UidBytes)
                                                         : item_r.uid_len;
    shifted    = uid_all << {off_c, 3'b000};
    left_bytes = 5'(cnia_pkg::UidBytes) - off_c;
    mismatch   = 1'b0;
    for (int i = 0; i < cnia_pkg::UidBytes; i++) begin
      if ((5'(i) < len_c) && (msg_all[127-8*i -: 8] != uid_all[127-8*i -: 8])) begin
        mismatch = 1'b1;
      end
    end

    alloc_nxt    = alloc_r;
    off_nxt      = off_r;
    next_req_nxt = next_req_r;
    res_nxt      = '0;

    if (local_id == '0) begin
      if (item_r.opcode == cnia_pkg::OpPoll) begin
        if (item_r.now_ms >= next_req_r) begin
          next_req_nxt               = dl_full;
          off_nxt                    = '0;
          res_nxt.request_valid      = 1'b1;
          res_nxt.request_first_byte = {pref_id_r, off_r == '0};
          res_nxt.request_uid_bytes  = shifted[127:80];
          res_nxt.request_uid_count  = (left_bytes > 5'(cnia_pkg::MaxReqUid))
                                       ? 3'(cnia_pkg::MaxReqUid) : left_bytes[2:0];
        end
      end else begin
        next_req_nxt = dl_full;
        if (item_r.from_anonymous || mismatch) begin
          off_nxt = '0;
        end else if (len_c < 5'(cnia_pkg::UidBytes)) begin
          off_nxt      = len_c;
          next_req_nxt = dl_part;
        end else begin
          alloc_nxt = item_r.assigned_node_id;
        end
      end
    end
    res_nxt.local_node_id = (static_id_r != '0) ? static_id_r : alloc_nxt;

    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r     <= '0;
      off_r       <= '0;
      next_req_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.commit) begin
        alloc_r    <= alloc_nxt;
        off_r      <= off_nxt;
        next_req_r <= next_req_nxt;
      end
    end
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.out_busy = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = res_r;

endmodule

// ===== design/cnia_ctrl.sv =====
// Controller: sequences load, remainder wait and commit of one word.
module cnia_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cnia_pkg::ctrl_stat_t stat,
  output cnia_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    in_stall   = state_r != StIdle;
    unique case (state_r)
      StIdle: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = StRun;
        end
      end
      StRun: begin
        if (!stat.div_busy) begin
          state_nxt = StFin;
        end
      end
      StFin: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/can_node_id_allocation_client.sv =====
// Top level of the CAN node-ID allocation client.
// From input accept to out_valid a word passes through load, the bit-serial remainder steps and commit.
// The next word is not accepted until the current one is committed, as the remainder unit is bit-serial.
// A held result does not block the next accept; its commit waits for the output register.
// Synchronous active-low reset restores register defaults and clears node ID,
// UID offset and request deadline.
module can_node_id_allocation_client (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cnia_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cnia_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  cnia_pkg::ctrl_cmd_t  cmd;
  cnia_pkg::ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  cnia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cnia_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/can_node_id_allocation_client_tb.sv =====
// Self-checking testbench for the CAN node-ID allocation client: directed table, then random words.
`timescale 1ns / 1ps

module can_node_id_allocation_client_tb;

  localparam int          CycleLimit  = 1_000_000;
  localparam int          DrainCycles = 40;
  localparam int          PhaseWords  = 190;
  localparam logic [63:0] UidHi       = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] UidLo       = 64'hFEDC_BA98_7654_3210;

  typedef struct {
    logic                be_reg_dummy_unused;
  } unused_t;

  typedef struct {
    logic                is_reg;
    logic [2:0]          reg_idx;
    logic [63:0]         reg_val;
    cnia_pkg::in_word_t  word;
    logic                typed_in;
    cnia_pkg::out_word_t want;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  cnia_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  cnia_pkg::out_word_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [63:0]         cfg_data;

  logic [6:0]  cfg_pref       = '0;
  logic [6:0]  cfg_static     = '0;
  logic [63:0] cfg_uid_hi     = '0;
  logic [63:0] cfg_uid_lo     = '0;
  logic [15:0] cfg_min_period = cnia_pkg::MinPeriodReset;
  logic [15:0] cfg_max_delay  = cnia_pkg::MaxDelayReset;
  logic [6:0]  alloc_id       = '0;
  logic [4:0]  uid_offset     = '0;
  logic [31:0] deadline_ms    = '0;

  cnia_pkg::out_word_t awaited_replies[$];
  plan_row_t           plan[$];
  int          burst_left     = 0;
  logic        gaps_on        = 1'b1;
  int          words_sent     = 0;
  int          ignored_words  = 0;
  int          reg_writes     = 0;
  int          replies_seen   = 0;
  int          requests_seen  = 0;
  int          mismatches     = 0;
  int          cycle_count    = 0;

  can_node_id_allocation_client i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] uid_byte(logic [127:0] v, int unsigned i);
    return v[(15 - i) * 8 +: 8];
  endfunction

  function automatic logic [6:0] current_node_id();
    return (cfg_static != 7'd0) ? cfg_static : alloc_id;
  endfunction

  function automatic logic [31:0] next_deadline(logic [31:0] now, logic [30:0] rnd);
    logic [31:0] extra;
    extra = (cfg_max_delay != 16'd0) ? ({1'b0, rnd} % {16'd0, cfg_max_delay}) : 32'd0;
    return now + {16'd0, cfg_min_period} + extra;
  endfunction

  function automatic cnia_pkg::out_word_t step_allocatee(cnia_pkg::in_word_t w);
    cnia_pkg::out_word_t r;
    logic [127:0] mine;
    int unsigned  off;
    int unsigned  cnt;
    int unsigned  len;
    int unsigned  i;
    logic         hit;
    r    = '0;
    mine = {cfg_uid_hi, cfg_uid_lo};
    if (current_node_id() == 7'd0) begin
      if (w.opcode == cnia_pkg::OpPoll) begin
        if (w.now_ms >= deadline_ms) begin
          off = (uid_offset > cnia_pkg::UidBytes) ? cnia_pkg::UidBytes : uid_offset;
          cnt = (cnia_pkg::UidBytes - off > cnia_pkg::MaxReqUid) ? cnia_pkg::MaxReqUid
                                                                 : cnia_pkg::UidBytes - off;
          deadline_ms = next_deadline(w.now_ms, w.random_draw);
          r.request_valid      = 1'b1;
          r.request_first_byte = {cfg_pref, uid_offset == 5'd0};
          r.request_uid_count  = cnt[2:0];
          for (i = 0; i < cnia_pkg::MaxReqUid; i++) begin
            r.request_uid_bytes = {r.request_uid_bytes[39:0],
                                   (i < cnt) ? uid_byte(mine, off + i) : 8'h00};
          end
          uid_offset = '0;
        end
      end else begin
        deadline_ms = next_deadline(w.now_ms, w.random_draw);
        if (w.from_anonymous) begin
          uid_offset = '0;
        end else begin
          len = (w.uid_len > cnia_pkg::UidBytes) ? cnia_pkg::UidBytes : w.uid_len;
          hit = 1'b1;
          for (i = 0; i < cnia_pkg::UidBytes; i++) begin
            if (i < len && uid_byte({w.msg_uid_upper, w.msg_uid_lower}, i) != uid_byte(mine, i))
              hit = 1'b0;
          end
          if (!hit) begin
            uid_offset = '0;
          end else if (len < cnia_pkg::UidBytes) begin
            uid_offset  = len[4:0];
            deadline_ms = deadline_ms - {16'd0, cfg_min_period};
          end else begin
            alloc_id = w.assigned_node_id;
          end
        end
      end
    end
    r.local_node_id = current_node_id();
    return r;
  endfunction

  function automatic cnia_pkg::in_word_t mk_word(logic op, logic [31:0] now, logic [30:0] rnd,
                                                 logic anon, logic [4:0] len, logic [63:0] hi,
                                                 logic [63:0] lo, logic [6:0] asg);
    cnia_pkg::in_word_t w;
    w.opcode           = op;
    w.now_ms           = now;
    w.random_draw      = rnd;
    w.from_anonymous   = anon;
    w.uid_len          = len;
    w.msg_uid_upper    = hi;
    w.msg_uid_lower    = lo;
    w.assigned_node_id = asg;
    return w;
  endfunction

  function automatic cnia_pkg::in_word_t random_word(logic claim);
    cnia_pkg::in_word_t w;
    logic [127:0] mine;
    logic [127:0] msg;
    int unsigned  pick;
    int unsigned  n;
    int unsigned  k;
    mine = {cfg_uid_hi, cfg_uid_lo};
    msg  = {$urandom, $urandom, $urandom, $urandom};
    w    = mk_word(cnia_pkg::OpAlloc, $urandom, 31'($urandom), 1'b0, 5'($urandom), '0, '0,
                   7'($urandom));
    pick = claim ? 50 : $urandom_range(0, 99);
    if (pick < 45) begin
      w.opcode = cnia_pkg::OpPoll;
      case ($urandom_range(0, 9))
        0:       w.now_ms = $urandom;
        1, 2:    w.now_ms = deadline_ms - $urandom_range(1, 2000);
        default: w.now_ms = deadline_ms + $urandom_range(0, 30);
      endcase
    end else if (pick < 90) begin
      if ($urandom_range(0, 7) != 0)
        w.now_ms = deadline_ms - $urandom_range(0, 1500);
      if (claim)
        n = cnia_pkg::UidBytes;
      else if ($urandom_range(0, 4) < 3)
        n = (uid_offset + cnia_pkg::MaxReqUid > cnia_pkg::UidBytes) ? cnia_pkg::UidBytes
                                                                    : uid_offset +
                                                                      cnia_pkg::MaxReqUid;
      else
        n = $urandom_range(0, cnia_pkg::UidBytes);
      for (k = 0; k < n; k++) msg[(15 - k) * 8 +: 8] = uid_byte(mine, k);
      if (!claim && pick >= 80 && n != 0) begin
        k = $urandom_range(0, n - 1);
        msg[(15 - k) * 8 +: 8] ^= 8'($urandom_range(1, 255));
      end
      w.uid_len = n[4:0];
      if (n == cnia_pkg::UidBytes && $urandom_range(0, 2) == 0)
        w.uid_len = 5'($urandom_range(cnia_pkg::UidBytes + 1, 31));
      w.from_anonymous = !claim && ($urandom_range(0, 19) == 0);
    end else begin
      w.opcode         = 1'($urandom);
      w.from_anonymous = 1'($urandom);
    end
    {w.msg_uid_upper, w.msg_uid_lower} = msg;
    if (claim)
      w.assigned_node_id = 7'($urandom_range(1, 127));
    else if (w.opcode == cnia_pkg::OpAlloc && w.uid_len >= cnia_pkg::UidBytes && msg == mine)
      w.assigned_node_id = '0;
    return w;
  endfunction

  task automatic plan_item(cnia_pkg::in_word_t w, logic typed_in, cnia_pkg::out_word_t want);
    plan_row_t row;
    row          = '{default: '0};
    row.word     = w;
    row.typed_in = typed_in;
    row.want     = want;
    plan.push_back(row);
  endtask

  task automatic plan_reg(logic [2:0] idx, logic [63:0] val);
    plan_row_t row;
    row         = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endtask

  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cnia_pkg::CfgPreferredId: cfg_pref       = val[6:0];
      cnia_pkg::CfgStaticId:    cfg_static     = val[6:0];
      cnia_pkg::CfgUidUpper:    cfg_uid_hi     = val;
      cnia_pkg::CfgUidLower:    cfg_uid_lo     = val;
      cnia_pkg::CfgMinPeriod:   cfg_min_period = val[15:0];
      cnia_pkg::CfgMaxDelay:    cfg_max_delay  = val[15:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(cnia_pkg::in_word_t w, logic typed_in, cnia_pkg::out_word_t want);
    cnia_pkg::out_word_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (current_node_id() != 7'd0) ignored_words++;
    predicted = step_allocatee(w);
    awaited_replies.push_back(typed_in ? want : predicted);
    words_sent++;
  endtask

  task automatic note_mismatch(string what, cnia_pkg::out_word_t want,
                               cnia_pkg::out_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: want v=%0d fb=%h uid=%h n=%0d id=%0d, got v=%0d fb=%h uid=%h n=%0d id=%0d",
               what, want.request_valid, want.request_first_byte, want.request_uid_bytes,
               want.request_uid_count, want.local_node_id, got.request_valid,
               got.request_first_byte, got.request_uid_bytes, got.request_uid_count,
               got.local_node_id);
  endtask

  always @(posedge clk) begin
    cnia_pkg::out_word_t want;
    cnia_pkg::out_word_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = out_data;
      replies_seen++;
      if (got.request_valid) requests_seen++;
      if (awaited_replies.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = awaited_replies.pop_front();
        if (got.request_valid !== want.request_valid ||
            got.request_first_byte !== want.request_first_byte ||
            got.request_uid_bytes !== want.request_uid_bytes ||
            got.request_uid_count !== want.request_uid_count ||
            got.local_node_id !== want.local_node_id)
          note_mismatch("word mismatch", want, got);
      end
    end
  end

  initial begin
    int unsigned run;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      case ($urandom_range(0, 9))
        0, 1: begin
          run = $urandom_range(1, 40);
          out_stall <= 1'b1;
        end
        2: begin
          run = $urandom_range(200, 400);
          out_stall <= 1'b0;
        end
        default: begin
          run = $urandom_range(1, 10);
          out_stall <= 1'($urandom);
        end
      endcase
      repeat (run - 1) @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** can_node_id_allocation_client: FAILED **");
    $finish;
  end

  initial begin
    int p;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = cnia_pkg::CfgPreferredId;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    plan_item(mk_word(cnia_pkg::OpPoll, 32'd0, 31'd0, 1'b0, 5'd0, '0, '0, 7'd0), 1'b1,
              {1'b1, 8'h01, 48'h0, 3'd6, 7'd0});
    plan_item(mk_word(cnia_pkg::OpPoll, 32'd599, 31'h7FFF_FFFF, 1'b0, 5'd0, '0, '0, 7'd0),
              1'b1, '0);
    plan_reg(cnia_pkg::CfgPreferredId, 64'd127);
    plan_reg(cnia_pkg::CfgUidUpper, UidHi);
    plan_reg(cnia_pkg::CfgUidLower, UidLo);
    plan_reg(cnia_pkg::CfgMinPeriod, 64'd0);
    plan_reg(cnia_pkg::CfgMaxDelay, 64'd0);
    plan_item(mk_word(cnia_pkg::OpAlloc, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 5'd16, UidHi,
                      UidLo, 7'd127), 1'b1, '0);
    plan_item(mk_word(cnia_pkg::OpAlloc, 32'd100, 31'd7, 1'b0, 5'd6,
                      {UidHi[63:16], 16'h5A5A}, '0, 7'd3), 1'b0, '0);
    plan_item(mk_word(cnia_pkg::OpPoll, 32'd100, 31'd9, 1'b0, 5'd0, '0, '0, 7'd0), 1'b0, '0);
    plan_item(mk_word(cnia_pkg::OpAlloc, 32'd200, 31'd0, 1'b0, 5'd14, UidHi,
                      {UidLo[63:16], 16'h0}, 7'd0), 1'b0, '0);
    plan_item(mk_word(cnia_pkg::OpPoll, 32'd200, 31'd0, 1'b0, 5'd0, '0, '0, 7'd0), 1'b0, '0);
    plan_item(mk_word(cnia_pkg::OpAlloc, 32'd300, 31'd0, 1'b0, 5'd9, UidHi,
                      {~UidLo[63:56], UidLo[55:0]}, 7'd0), 1'b0, '0);
    plan_item(mk_word(cnia_pkg::OpAlloc, 32'd350, 31'd0, 1'b0, 5'd0, '0, '0, 7'd0), 1'b0, '0);
    plan_item(mk_word(cnia_pkg::OpAlloc, 32'd380, 31'd0, 1'b0, 5'd31, UidHi, UidLo, 7'd0),
              1'b1, '0);
    plan_item(mk_word(cnia_pkg::OpAlloc, 32'd400, 31'd0, 1'b0, 5'd16, '1, '1, 7'd127),
              1'b1, '0);
    plan_reg(cnia_pkg::CfgMinPeriod, 64'd65535);
    plan_reg(cnia_pkg::CfgMaxDelay, 64'd65535);
    plan_item(mk_word(cnia_pkg::OpPoll, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0, 5'd0, '0, '0,
                      7'd0), 1'b0, '0);
    plan_item(mk_word(cnia_pkg::OpPoll, 32'd0, 31'd0, 1'b0, 5'd0, '0, '0, 7'd0), 1'b0, '0);
    plan_item(mk_word(cnia_pkg::OpAlloc, 32'd0, 31'd0, 1'b0, 5'd12, UidHi,
                      {UidLo[63:32], 32'h0}, 7'd0), 1'b0, '0);
    plan_item(mk_word(cnia_pkg::OpPoll, 32'hFFFF_FFFF, 31'd12345, 1'b0, 5'd0, '0, '0, 7'd0),
              1'b0, '0);
    plan_reg(cnia_pkg::CfgStaticId, 64'd127);
    plan_reg(cnia_pkg::CfgMaxDelay, 64'd1);
    plan_item(mk_word(cnia_pkg::OpPoll, 32'hFFFF_FFFF, 31'd0, 1'b0, 5'd0, '0, '0, 7'd0), 1'b1,
              {1'b0, 8'h00, 48'h0, 3'd0, 7'd127});
    plan_item(mk_word(cnia_pkg::OpAlloc, 32'd5, 31'd0, 1'b0, 5'd16, UidHi, UidLo, 7'd5), 1'b1,
              {1'b0, 8'h00, 48'h0, 3'd0, 7'd127});
    plan_reg(cnia_pkg::CfgStaticId, 64'd0);
    plan_reg(cnia_pkg::CfgPreferredId, 64'd0);
    plan_reg(cnia_pkg::CfgMinPeriod, 64'd600);
    plan_reg(cnia_pkg::CfgMaxDelay, 64'd400);
    plan_item(mk_word(cnia_pkg::OpPoll, 32'h8000_0000, 31'd0, 1'b0, 5'd0, '0, '0, 7'd0),
              1'b0, '0);

    foreach (plan[r]) begin
      if (plan[r].is_reg) begin
        settle();
        write_reg(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        send_word(plan[r].word, plan[r].typed_in, plan[r].want);
      end
    end

    for (p = 0; p < 6; p++) begin
      settle();
      write_reg(cnia_pkg::CfgPreferredId,
                (p == 0) ? 64'd0 : (p == 1) ? 64'd127 : $urandom_range(0, 127));
      write_reg(cnia_pkg::CfgStaticId, 64'd0);
      write_reg(cnia_pkg::CfgUidUpper, (p == 2) ? '1 : (p == 3) ? '0 : {$urandom, $urandom});
      write_reg(cnia_pkg::CfgUidLower, (p == 2) ? '1 : (p == 3) ? '0 : {$urandom, $urandom});
      write_reg(cnia_pkg::CfgMinPeriod,
                (p == 1) ? 64'd0 : (p == 2) ? 64'd65535 : $urandom_range(0, 3000));
      write_reg(cnia_pkg::CfgMaxDelay, (p == 1) ? 64'd1 : (p == 2) ? 64'd65535 :
                                       (p == 3) ? 64'd0 : $urandom_range(1, 65535));
      gaps_on = (p != 1 && p != 4);
      repeat (PhaseWords) send_word(random_word(1'b0), 1'b0, '0);
      if (p == 3) begin
        settle();
        write_reg(cnia_pkg::CfgStaticId, $urandom_range(1, 127));
        repeat (20) send_word(random_word(1'b0), 1'b0, '0);
        settle();
        write_reg(cnia_pkg::CfgStaticId, 64'd0);
      end
    end

    // claim a node ID last: it holds for the rest of the run
    send_word(random_word(1'b1), 1'b0, '0);
    repeat (6) send_word(random_word(1'b0), 1'b0, '0);
    settle();

    $display("Sent %0d words (%0d while holding a node ID) over %0d register writes.",
             words_sent, ignored_words, reg_writes);
    $display("Checked %0d replies, %0d of them requests; %0d mismatches, %0d replies missing.",
             replies_seen, requests_seen, mismatches, awaited_replies.size());
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("** can_node_id_allocation_client: PASSED **");
    end else begin
      $display("** can_node_id_allocation_client: FAILED **");
    end
    $finish;
  end

endmodule
